>>> sv/utc2e_pkg.sv
// ----------------------------------------------------------------------------
// utc2e_pkg
// Shared widths, calendar constants, the days-before-month table and the
// stage record for the UTC date to epoch seconds converter.
// ----------------------------------------------------------------------------
package utc2e_pkg;

  localparam int unsigned YEAR_W   = 10;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned EPOCH_W  = 35;

  // Full calendar year fits in 12 bits (1900 .. 2923)
  localparam int unsigned FULL_YEAR_W = 12;
  // Whole-year day count up to 1023 years past 1900
  localparam int unsigned YEAR_DAYS_W = 19;
  localparam int unsigned MONTH_DAYS_W = 9;
  localparam int unsigned QUOT_W = 5;
  localparam int unsigned LEAPS_W = 10;

  localparam logic [FULL_YEAR_W-1:0]  YEAR_BASE      = 12'd1900;
  localparam logic [YEAR_W-1:0]       EPOCH_YEAR_OFF = 10'd70;
  localparam logic [YEAR_DAYS_W-1:0]  DAYS_PER_YEAR  = 19'd365;
  // Leap years in 1 .. 1969
  localparam logic [LEAPS_W-1:0]      LEAPS_1969     = 10'd477;
  // floor(n / 25) = (n * 41) >> 10 for n < 1024
  localparam logic [14:0]             RECIP_25       = 15'd41;
  localparam int unsigned             RECIP_SHIFT    = 10;
  localparam logic [LEAPS_W-1:0]      QUARTERS_PER_CENTURY = 10'd25;
  localparam logic [MONTH_W-1:0]      MONTHS_PER_YEAR = 4'd12;

  localparam logic [EPOCH_W-1:0]      HOURS_PER_DAY    = 35'd24;
  localparam logic [EPOCH_W-1:0]      MINUTES_PER_HOUR = 35'd60;
  localparam logic [EPOCH_W-1:0]      SECONDS_PER_MIN  = 35'd60;

  typedef struct packed {
    logic                valid;
    logic [EPOCH_W-1:0]  days;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } day_item_t;

  // Days before each month; entry 12 is the whole year
  function automatic logic [MONTH_DAYS_W-1:0] days_before_month(
    input logic               leap,
    input logic [MONTH_W-1:0] mon
  );
    logic [MONTH_DAYS_W-1:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    if (leap && (mon >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

>>> sv/utc2e_days.sv
// ----------------------------------------------------------------------------
// utc2e_days
// Three-stage front end: input register, century quotients, day count
// (whole years, earlier months, day of month minus one).
// ----------------------------------------------------------------------------
module utc2e_days (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [utc2e_pkg::YEAR_W-1:0]      year_since_1900_i,
  input  logic [utc2e_pkg::MONTH_W-1:0]     month_index_i,
  input  logic [utc2e_pkg::DAY_W-1:0]       day_of_month_i,
  input  logic [utc2e_pkg::HOUR_W-1:0]      hour_of_day_i,
  input  logic [utc2e_pkg::MINUTE_W-1:0]    minute_of_hour_i,
  input  logic [utc2e_pkg::SECOND_W-1:0]    second_of_minute_i,
  output utc2e_pkg::day_item_t              day_o
);

  // ---- stage 1: input register ----
  logic                             v1_q;
  logic [utc2e_pkg::YEAR_W-1:0]     yr1_q;
  logic [utc2e_pkg::MONTH_W-1:0]    mon1_q;
  logic [utc2e_pkg::DAY_W-1:0]      mday1_q;
  logic [utc2e_pkg::HOUR_W-1:0]     hour1_q;
  logic [utc2e_pkg::MINUTE_W-1:0]   min1_q;
  logic [utc2e_pkg::SECOND_W-1:0]   sec1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    yr1_q   <= year_since_1900_i;
    mon1_q  <= month_index_i;
    mday1_q <= day_of_month_i;
    hour1_q <= hour_of_day_i;
    min1_q  <= minute_of_hour_i;
    sec1_q  <= second_of_minute_i;
  end

  // ---- stage 2: full year, quotients by 100 ----
  logic [utc2e_pkg::FULL_YEAR_W-1:0] yf_d, y1_d;
  logic [14:0]                       prod0, prod1;
  logic [utc2e_pkg::QUOT_W-1:0]      q0_d, q1_d;
  logic [utc2e_pkg::MONTH_W-1:0]     mon2_d;

  always_comb begin
    yf_d  = utc2e_pkg::FULL_YEAR_W'(yr1_q) + utc2e_pkg::YEAR_BASE;
    y1_d  = yf_d - 12'd1;
    // floor(y/100) = floor(floor(y/4) / 25)
    prod0 = 15'(yf_d[11:2]) * utc2e_pkg::RECIP_25;
    prod1 = 15'(y1_d[11:2]) * utc2e_pkg::RECIP_25;
    q0_d  = prod0[14:utc2e_pkg::RECIP_SHIFT];
    q1_d  = prod1[14:utc2e_pkg::RECIP_SHIFT];
    mon2_d = (mon1_q > utc2e_pkg::MONTHS_PER_YEAR) ? utc2e_pkg::MONTHS_PER_YEAR : mon1_q;
  end

  logic                              v2_q;
  logic [utc2e_pkg::FULL_YEAR_W-1:0] yf2_q, y12_q;
  logic [utc2e_pkg::QUOT_W-1:0]      q02_q, q12_q;
  logic                              ge70_2_q;
  logic [utc2e_pkg::YEAR_W-1:0]      yoff2_q;
  logic [utc2e_pkg::MONTH_W-1:0]     mon2_q;
  logic [utc2e_pkg::DAY_W-1:0]       mday2_q;
  logic [utc2e_pkg::HOUR_W-1:0]      hour2_q;
  logic [utc2e_pkg::MINUTE_W-1:0]    min2_q;
  logic [utc2e_pkg::SECOND_W-1:0]    sec2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    yf2_q    <= yf_d;
    y12_q    <= y1_d;
    q02_q    <= q0_d;
    q12_q    <= q1_d;
    ge70_2_q <= (yr1_q >= utc2e_pkg::EPOCH_YEAR_OFF);
    yoff2_q  <= yr1_q - utc2e_pkg::EPOCH_YEAR_OFF;
    mon2_q   <= mon2_d;
    mday2_q  <= mday1_q;
    hour2_q  <= hour1_q;
    min2_q   <= min1_q;
    sec2_q   <= sec1_q;
  end

  // ---- stage 3: day count ----
  logic                                 leap;
  logic [utc2e_pkg::LEAPS_W-1:0]        leaps_since;
  logic [utc2e_pkg::YEAR_DAYS_W-1:0]    year_days;
  logic [utc2e_pkg::MONTH_DAYS_W-1:0]   month_days;
  logic [utc2e_pkg::EPOCH_W-1:0]        days_d;

  always_comb begin
    // divisible by 4, and not a century unless divisible by 400
    leap = (yf2_q[1:0] == 2'b00) &&
           ((yf2_q[11:2] != (10'(q02_q) * utc2e_pkg::QUARTERS_PER_CENTURY)) ||
            (q02_q[1:0] == 2'b00));
    leaps_since = 10'(y12_q[11:2]) - 10'(q12_q) + 10'(q12_q[4:2]) - utc2e_pkg::LEAPS_1969;
    year_days = ge70_2_q ?
                (19'(yoff2_q) * utc2e_pkg::DAYS_PER_YEAR + 19'(leaps_since)) : '0;
    month_days = utc2e_pkg::days_before_month(leap, mon2_q);
    // day zero wraps to minus one, modulo 2^35
    days_d = utc2e_pkg::EPOCH_W'(year_days) + utc2e_pkg::EPOCH_W'(month_days) +
             utc2e_pkg::EPOCH_W'(mday2_q) - 35'd1;
  end

  logic                              v3_q;
  logic [utc2e_pkg::EPOCH_W-1:0]     days3_q;
  logic [utc2e_pkg::HOUR_W-1:0]      hour3_q;
  logic [utc2e_pkg::MINUTE_W-1:0]    min3_q;
  logic [utc2e_pkg::SECOND_W-1:0]    sec3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    days3_q <= days_d;
    hour3_q <= hour2_q;
    min3_q  <= min2_q;
    sec3_q  <= sec2_q;
  end

  assign day_o.valid  = v3_q;
  assign day_o.days   = days3_q;
  assign day_o.hour   = hour3_q;
  assign day_o.minute = min3_q;
  assign day_o.second = sec3_q;

`ifndef ASSERT_OFF
  // reciprocal quotient must be floor(y/100) for the year before
  a_q1_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> ((13'(q12_q) * 13'd100 <= 13'(y12_q)) &&
              (13'(y12_q) < 13'(q12_q) * 13'd100 + 13'd100)))
    else $error("century quotient of previous year out of range");

  a_q0_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> ((13'(q02_q) * 13'd100 <= 13'(yf2_q)) &&
              (13'(yf2_q) < 13'(q02_q) * 13'd100 + 13'd100)))
    else $error("century quotient of given year out of range");

  // years before the epoch contribute nothing beyond the given year
  a_pre_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !ge70_2_q) |=> (days3_q + 35'd1 ==
      utc2e_pkg::EPOCH_W'($past(month_days)) + utc2e_pkg::EPOCH_W'($past(mday2_q))))
    else $error("pre-epoch year added whole-year days");
`endif

endmodule

>>> sv/utc2e_scale.sv
// ----------------------------------------------------------------------------
// utc2e_scale
// Three-stage back end: days to hours, hours to minutes, minutes to seconds,
// all modulo 2^35.
// ----------------------------------------------------------------------------
module utc2e_scale (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  utc2e_pkg::day_item_t             day_i,
  output logic                             valid_o,
  output logic [utc2e_pkg::EPOCH_W-1:0]    seconds_o
);

  logic                              v4_q, v5_q, v6_q;
  logic [utc2e_pkg::EPOCH_W-1:0]     hours4_q, mins5_q, secs6_q;
  logic [utc2e_pkg::MINUTE_W-1:0]    min4_q;
  logic [utc2e_pkg::SECOND_W-1:0]    sec4_q, sec5_q;

  logic [utc2e_pkg::EPOCH_W-1:0]     hours4_d, mins5_d, secs6_d;

  always_comb begin
    hours4_d = day_i.days * utc2e_pkg::HOURS_PER_DAY + utc2e_pkg::EPOCH_W'(day_i.hour);
    mins5_d  = hours4_q * utc2e_pkg::MINUTES_PER_HOUR + utc2e_pkg::EPOCH_W'(min4_q);
    secs6_d  = mins5_q * utc2e_pkg::SECONDS_PER_MIN + utc2e_pkg::EPOCH_W'(sec5_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= day_i.valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hours4_q <= hours4_d;
    min4_q   <= day_i.minute;
    sec4_q   <= day_i.second;
    mins5_q  <= mins5_d;
    sec5_q   <= sec4_q;
    secs6_q  <= secs6_d;
  end

  assign valid_o   = v6_q;
  assign seconds_o = secs6_q;

`ifndef ASSERT_OFF
  // one result for each day record, after the hours, minutes and seconds registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q == $past(day_i.valid, 3))
    else $error("scale pipeline lost or invented an item");
`endif

endmodule

>>> sv/utc_date_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// utc_date_to_epoch_seconds
// Broken-down UTC date and time to seconds since 1970-01-01 00:00:00.
// ----------------------------------------------------------------------------
// A date is taken on every clock edge with start high; busy is held low,
// so one date per cycle is sustained. The result appears on epoch_seconds_o
// with done_o high for a single cycle, in the order the dates went in;
// there is no backpressure and the result must be captured in that cycle.
// The path runs through six register stages: input, century quotients,
// day count, then hours, minutes and seconds scaling.
// Leap years follow the Gregorian rule; years before 1970 add no whole-year
// days. Day, hour, minute and second are not range-checked, and the sum wraps
// modulo 2^35.
module utc_date_to_epoch_seconds (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [utc2e_pkg::YEAR_W-1:0]     year_since_1900_i,
  input  logic [utc2e_pkg::MONTH_W-1:0]    month_index_i,
  input  logic [utc2e_pkg::DAY_W-1:0]      day_of_month_i,
  input  logic [utc2e_pkg::HOUR_W-1:0]     hour_of_day_i,
  input  logic [utc2e_pkg::MINUTE_W-1:0]   minute_of_hour_i,
  input  logic [utc2e_pkg::SECOND_W-1:0]   second_of_minute_i,
  output logic                             done_o,
  output logic [utc2e_pkg::EPOCH_W-1:0]    epoch_seconds_o
);

  utc2e_pkg::day_item_t day_item;
  logic                 accept;

  // the pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  utc2e_days u_days (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (accept),
    .year_since_1900_i  (year_since_1900_i),
    .month_index_i      (month_index_i),
    .day_of_month_i     (day_of_month_i),
    .hour_of_day_i      (hour_of_day_i),
    .minute_of_hour_i   (minute_of_hour_i),
    .second_of_minute_i (second_of_minute_i),
    .day_o              (day_item)
  );

  utc2e_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .day_i     (day_item),
    .valid_o   (done_o),
    .seconds_o (epoch_seconds_o)
  );

endmodule

>>> verif/tb_utc_date_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// tb_utc_date_to_epoch_seconds
// Drives broken-down UTC dates into the converter with random gaps and checks
// every epoch count against a local calendar predictor, in transfer order.
// ----------------------------------------------------------------------------
module tb_utc_date_to_epoch_seconds;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [utc2e_pkg::YEAR_W-1:0]   year;
    logic [utc2e_pkg::MONTH_W-1:0]  month;
    logic [utc2e_pkg::DAY_W-1:0]    day;
    logic [utc2e_pkg::HOUR_W-1:0]   hour;
    logic [utc2e_pkg::MINUTE_W-1:0] minute;
    logic [utc2e_pkg::SECOND_W-1:0] second;
  } utc_date_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          done_o;
  logic [utc2e_pkg::EPOCH_W-1:0] epoch_seconds_o;
  utc_date_t                     cur_date = '0;

  utc_date_t                     pending_dates[$];
  logic [utc2e_pkg::EPOCH_W-1:0] expected_epochs[$];
  utc_date_t                     next_date;
  int unsigned                   gap_left = 0;
  int unsigned                   burst_left = 0;
  int unsigned                   mismatches = 0;

  always #6 clk_i = ~clk_i;

  utc_date_to_epoch_seconds u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .year_since_1900_i  (cur_date.year),
    .month_index_i      (cur_date.month),
    .day_of_month_i     (cur_date.day),
    .hour_of_day_i      (cur_date.hour),
    .minute_of_hour_i   (cur_date.minute),
    .second_of_minute_i (cur_date.second),
    .done_o             (done_o),
    .epoch_seconds_o    (epoch_seconds_o)
  );

  // Calendar arithmetic in 64 bits; only the low 35 bits are kept, so a day
  // of zero wraps the same way modulo 2^35.
  function automatic logic [utc2e_pkg::EPOCH_W-1:0] epoch_of_date(input utc_date_t d);
    logic [63:0] days;
    logic [63:0] total;
    int unsigned full_year;
    int unsigned prev;
    int unsigned mon;
    int unsigned m;
    bit          leap;
    full_year = 1900 + int'(d.year);
    mon = (d.month > 12) ? 12 : int'(d.month);
    leap = (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
    days = 64'd0;
    if (d.year > 70) begin
      prev = full_year - 1;
      days = 64'(365 * (int'(d.year) - 70))
           + 64'(prev / 4 - prev / 100 + prev / 400)
           - 64'(1969 / 4 - 1969 / 100 + 1969 / 400);
    end
    for (m = 0; m < mon; m++) begin
      if (m == 1) begin
        days += leap ? 64'd29 : 64'd28;
      end else if (m == 3 || m == 5 || m == 8 || m == 10) begin
        days += 64'd30;
      end else begin
        days += 64'd31;
      end
    end
    days = days + 64'(d.day) - 64'd1;
    total = days * 64'd24 + 64'(d.hour);
    total = total * 64'd60 + 64'(d.minute);
    total = total * 64'd60 + 64'(d.second);
    return total[utc2e_pkg::EPOCH_W-1:0];
  endfunction

  task automatic add_date(input int unsigned y, input int unsigned mo, input int unsigned d,
                          input int unsigned h, input int unsigned mi, input int unsigned s);
    utc_date_t t;
    t.year   = y[utc2e_pkg::YEAR_W-1:0];
    t.month  = mo[utc2e_pkg::MONTH_W-1:0];
    t.day    = d[utc2e_pkg::DAY_W-1:0];
    t.hour   = h[utc2e_pkg::HOUR_W-1:0];
    t.minute = mi[utc2e_pkg::MINUTE_W-1:0];
    t.second = s[utc2e_pkg::SECOND_W-1:0];
    pending_dates.push_back(t);
  endtask

  // Driver: record the transfer, then either idle or present the next date
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_epochs.push_back(epoch_of_date(cur_date));
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (pending_dates.size() != 0) begin
          next_date = pending_dates.pop_front();
          cur_date <= next_date;
          start <= 1'b1;
          if (burst_left != 0) begin
            burst_left = burst_left - 1;
            gap_left = 0;
          end else if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 40);
            gap_left = 0;
          end else if ($urandom_range(0, 9) < 5) begin
            gap_left = 0;
          end else if ($urandom_range(0, 9) < 8) begin
            gap_left = $urandom_range(1, 3);
          end else begin
            gap_left = $urandom_range(8, 40);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so each strobe is checked at once
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_epochs.size() == 0) begin
        $error("epoch_seconds: unexpected result %0d", epoch_seconds_o);
        mismatches++;
      end else if (epoch_seconds_o !== expected_epochs[0]) begin
        $error("epoch_seconds: expected %0d, actual %0d", expected_epochs[0],
               epoch_seconds_o);
        mismatches++;
        void'(expected_epochs.pop_front());
      end else begin
        void'(expected_epochs.pop_front());
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned y, mo, d, h, mi, s;

    // Directed: epoch itself, field extremes, leap rules, month saturation
    add_date(70, 0, 1, 0, 0, 0);
    add_date(0, 0, 1, 0, 0, 0);
    add_date(69, 11, 31, 23, 59, 59);
    add_date(68, 2, 1, 0, 0, 0);
    add_date(70, 0, 0, 0, 0, 0);
    add_date(71, 0, 1, 0, 0, 0);
    add_date(72, 2, 1, 0, 0, 0);
    add_date(100, 1, 29, 12, 0, 0);
    add_date(100, 2, 1, 0, 0, 0);
    add_date(0, 2, 1, 0, 0, 0);
    add_date(200, 2, 1, 0, 0, 0);
    add_date(500, 2, 1, 0, 0, 0);
    add_date(124, 11, 31, 23, 59, 60);
    add_date(124, 12, 1, 0, 0, 0);
    add_date(123, 13, 1, 0, 0, 0);
    add_date(1023, 15, 31, 31, 63, 63);
    add_date(1023, 11, 31, 23, 59, 60);
    add_date(1023, 0, 0, 0, 0, 0);
    add_date(0, 0, 0, 0, 0, 0);
    add_date(70, 15, 0, 31, 63, 63);
    add_date(512, 7, 16, 16, 32, 32);
    add_date(341, 5, 10, 10, 21, 42);

    for (i = 0; i < 800; i++) begin
      y  = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 1023);
      mo = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 11) : $urandom_range(0, 15);
      d  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 31) : $urandom_range(0, 31);
      h  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 23) : $urandom_range(0, 31);
      mi = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 59) : $urandom_range(0, 63);
      s  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 60) : $urandom_range(0, 63);
      add_date(y, mo, d, h, mi, s);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_dates.size() != 0 || start) begin
      @(posedge clk_i);
    end
    i = 0;
    while (expected_epochs.size() != 0 && i < 200) begin
      @(posedge clk_i);
      i++;
    end
    repeat (12) @(posedge clk_i);
    if (expected_epochs.size() != 0) begin
      $error("epoch_seconds: %0d results never arrived", expected_epochs.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
sv/utc2e_pkg.sv
sv/utc2e_days.sv
sv/utc2e_scale.sv
sv/utc_date_to_epoch_seconds.sv
verif/tb_utc_date_to_epoch_seconds.sv
